FILE: hw/rtl/npcs_pkg.sv
// Shared types and constants for the nearest palette color search block.
package npcs_pkg;

  // Palette size: one cell per entry
  localparam int NPCS_DEPTH = 256;
  localparam int IDX_W      = $clog2(NPCS_DEPTH);
  localparam int CNT_W      = 9;
  localparam int CHAN_W     = 8;
  // 4 * 255 * 255 = 260100 fits in 18 bits
  localparam int DIST_W     = 18;

  localparam logic [7:0] EMPTY_INDEX = 8'hFF;

  typedef enum logic {
    ACT_WRITE    = 1'b0,
    ACT_CLASSIFY = 1'b1
  } act_e;

  // Word travelling down the cell chain
  typedef struct packed {
    act_e                action;
    logic [7:0]          slot;
    logic [CHAN_W-1:0]   red;
    logic [CHAN_W-1:0]   green;
    logic [CHAN_W-1:0]   blue;
    logic [CHAN_W-1:0]   alpha;
    logic [DIST_W-1:0]   best;
    logic [IDX_W-1:0]    idx;
    logic                has;
  } token_t;

endpackage

FILE: hw/rtl/npcs_ifs.sv
// Valid/ready channel interfaces for input words and result words.
interface npcs_in_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [7:0] entry_index;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic [7:0] alpha;

  modport source (output valid, action, entry_index, red, green, blue, alpha,
                  input ready);
  modport sink   (input valid, action, entry_index, red, green, blue, alpha,
                  output ready);
endinterface

interface npcs_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] palette_index;

  modport source (output valid, palette_index, input ready);
  modport sink   (input valid, palette_index, output ready);
endinterface

FILE: hw/rtl/nearest_palette_color_search.sv
// Top level: palette store and nearest-color search as a chain of cells.
//
// Each palette entry lives in its own cell of a chain of NPCS_DEPTH (256) cells. Every
// input word, palette write or classify, enters cell 0 and moves one cell per cycle unless
// the chain holds; a write lands in the cell whose index matches entry_index, and a
// classify picks up the closest entry in use as it passes, so words keep their order
// exactly. One word is taken per cycle unless the chain holds; a classify result leaves
// from the last cell's register, and writes produce no result. When out ready is low with
// a result waiting, the whole chain holds and in ready drops. palette_count is a plain
// register; change it only while no word is in the chain. Entries need no clearing after reset.
module nearest_palette_color_search (
  input  logic                         clk,
  input  logic                         rst_n,
  npcs_in_if.sink                      in_chan,
  npcs_out_if.source                   out_chan,
  input  logic                         cfg_we,
  input  logic [npcs_pkg::CNT_W-1:0]   cfg_wdata
);
  import npcs_pkg::*;

  logic [CNT_W-1:0] cnt_r;
  logic             advance;
  logic             valid_w [NPCS_DEPTH+1];
  token_t           tok_w   [NPCS_DEPTH+1];
  token_t           last_tok;

  // Palette count register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cfg_we) begin
      cnt_r <= cfg_wdata;
    end
  end

  // Chain moves unless a result is stalled at the end
  assign advance      = !out_chan.valid || out_chan.ready;
  assign in_chan.ready = advance && rst_n;

  // Word entering cell 0
  assign valid_w[0] = in_chan.valid;
  always_comb begin
    tok_w[0]        = '0;
    tok_w[0].action = act_e'(in_chan.action);
    tok_w[0].slot   = in_chan.entry_index;
    tok_w[0].red    = in_chan.red;
    tok_w[0].green  = in_chan.green;
    tok_w[0].blue   = in_chan.blue;
    tok_w[0].alpha  = in_chan.alpha;
  end

  for (genvar i = 0; i < NPCS_DEPTH; i++) begin : g_cell
    npcs_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .advance  (advance),
      .cell_idx (IDX_W'(i)),
      .count    (cnt_r),
      .valid_i  (valid_w[i]),
      .token_i  (tok_w[i]),
      .valid_o  (valid_w[i+1]),
      .token_o  (tok_w[i+1])
    );
  end

  // Last cell output doubles as the result register
  assign last_tok               = tok_w[NPCS_DEPTH];
  assign out_chan.valid         = valid_w[NPCS_DEPTH] && (last_tok.action == ACT_CLASSIFY);
  assign out_chan.palette_index = last_tok.has ? 8'(last_tok.idx) : EMPTY_INDEX;

  // Nonempty palette always yields a match
  a_match_found: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && (cnt_r != '0)) |-> last_tok.has)
    else $error("classify result without a match on nonempty palette");

  // Chosen index lies within the entries in use
  a_index_in_use: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && last_tok.has) |-> ({1'b0, last_tok.idx} < cnt_r))
    else $error("result index beyond palette count");

  // Reset empties the chain
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_chan.valid)
    else $error("result valid right after reset");

endmodule

FILE: hw/rtl/npcs_cell.sv
// One chain cell: holds a palette entry and updates the running best match.
module npcs_cell (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    advance,
  input  logic [npcs_pkg::IDX_W-1:0] cell_idx,
  input  logic [npcs_pkg::CNT_W-1:0] count,
  input  logic                    valid_i,
  input  npcs_pkg::token_t        token_i,
  output logic                    valid_o,
  output npcs_pkg::token_t        token_o
);
  import npcs_pkg::*;

  logic [31:0]         entry_r;
  logic                valid_r;
  token_t              token_r;
  token_t              token_nxt;
  logic                hit_write;
  logic                in_use;
  logic                take;
  logic [DIST_W-1:0]   dist_sum;

  function automatic logic [2*CHAN_W-1:0] sq_diff(input logic [CHAN_W-1:0] a,
                                                  input logic [CHAN_W-1:0] b);
    logic [CHAN_W-1:0] d;
    d = (a > b) ? (a - b) : (b - a);
    return d * d;
  endfunction

  // Entry layout: red 7..0, green 15..8, blue 23..16, alpha 31..24
  always_comb begin
    dist_sum = DIST_W'(sq_diff(token_i.red,   entry_r[7:0]))
             + DIST_W'(sq_diff(token_i.green, entry_r[15:8]))
             + DIST_W'(sq_diff(token_i.blue,  entry_r[23:16]))
             + DIST_W'(sq_diff(token_i.alpha, entry_r[31:24]));
  end

  assign hit_write = valid_i && (token_i.action == ACT_WRITE)
                   && (token_i.slot == 8'(cell_idx));
  assign in_use    = ({1'b0, cell_idx} < count);
  // strict less-than: lower index keeps ties
  assign take      = valid_i && (token_i.action == ACT_CLASSIFY) && in_use
                   && (!token_i.has || (dist_sum < token_i.best));

  always_comb begin
    token_nxt = token_i;
    if (take) begin
      token_nxt.best = dist_sum;
      token_nxt.idx  = cell_idx;
      token_nxt.has  = 1'b1;
    end
  end

  // Palette entry storage, no reset
  always_ff @(posedge clk) begin
    if (advance && hit_write) begin
      entry_r <= {token_i.alpha, token_i.blue, token_i.green, token_i.red};
    end
  end

  // Hand the word to the next cell
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (advance) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      token_r <= token_nxt;
    end
  end

  assign valid_o = valid_r;
  assign token_o = token_r;

endmodule
